// ----- sv/scalar_kalman_filter_top_macros.svh -----
// Assertion macros used by the filter's top-level RTL.
`ifndef SCALAR_KALMAN_FILTER_TOP_MACROS_SVH
`define SCALAR_KALMAN_FILTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/skf_pkg.sv -----
`default_nettype none
package skf_pkg;

    localparam int SKF_FRAC_BITS = 16;
    localparam int SKF_GAIN_BITS = 16;

    localparam int EST_W = 32;
    localparam int COV_W = 31;
    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_EST   = 2'd0,
        CFG_INIT_COV   = 2'd1,
        CFG_PROC_NOISE = 2'd2,
        CFG_MEAS_NOISE = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_RELOAD = 1'b1
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic signed [EST_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [EST_W-1:0] estimate;
        logic [COV_W-1:0]        covariance;
    } t_out_item;

    // Status of the arithmetic core as seen by the sequencer above it.
    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

endpackage
`default_nettype wire

// ----- sv/scalar_kalman_filter_top.sv -----
// One-dimensional Kalman filter with an identity process model, in signed fixed point
// (FRAC_BITS fraction bits, gain with GAIN_BITS fraction bits). A filter transaction adds the
// process noise to the covariance (saturating), forms the gain K = P/(P+R) on a radix-2
// restoring divider, one quotient bit per cycle, and then runs K times the innovation and
// (1-K) times P together on a shift-add multiplier, one gain bit per cycle. When the
// measurement noise is zero the division is skipped. A reload transaction loads the initial
// registers into the filter state on acceptance and passes through the hold state to the
// result register without using the core. A result that finds the previous one still
// waiting in the output register stays in the hold state until that one is taken. The
// input is not ready while a transaction is in progress, but a finished result waits in the
// output register, so the next transaction may be accepted while it is held, in the cycle
// after it was loaded; one filter transaction thus finishes before the next is taken.
// Configuration registers are written through a simple write port and should only be
// changed while the block is idle.
`default_nettype none
`include "scalar_kalman_filter_top_macros.svh"
module scalar_kalman_filter_top #(
    parameter int FRAC_BITS = skf_pkg::SKF_FRAC_BITS,
    parameter int GAIN_BITS = skf_pkg::SKF_GAIN_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire skf_pkg::t_in_item                   i_in_data,
    // Output channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output skf_pkg::t_out_item                       o_out_data,
    // Configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [skf_pkg::CFG_W-1:0]           i_cfg_data
);
    import skf_pkg::*;

    // Reset values of 1.0 and 4.0 in the chosen fixed-point format.
    localparam logic [COV_W-1:0] Q_ONE  = COV_W'(1) << FRAC_BITS;
    localparam logic [COV_W-1:0] Q_FOUR = COV_W'(4) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic signed [EST_W-1:0] r_init_est;
    logic [COV_W-1:0]        r_init_cov;
    logic [COV_W-1:0]        r_q;
    logic [COV_W-1:0]        r_r;
    logic signed [EST_W-1:0] r_est;
    logic [COV_W-1:0]        r_cov;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    logic                    w_accept;
    logic                    w_start;
    logic                    w_load_out;
    t_core_stat              w_core_stat;
    logic signed [EST_W-1:0] w_core_est;
    logic [COV_W-1:0]        w_core_cov;

    // The input is taken only when the sequencer is idle; results leave through r_out_data.
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_start    = w_accept && (i_in_data.op == OP_FILTER);
    assign w_load_out = (r_state == S_HOLD) && (!r_out_valid || i_out_ready);

    // Configuration registers: indexes beyond the list do not exist in a two-bit index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_est <= '0;
            r_init_cov <= Q_ONE;
            r_q        <= Q_ONE;
            r_r        <= Q_FOUR;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_INIT_EST:   r_init_est <= $signed(i_cfg_data);
                CFG_INIT_COV:   r_init_cov <= i_cfg_data[COV_W-1:0];
                CFG_PROC_NOISE: r_q        <= i_cfg_data[COV_W-1:0];
                CFG_MEAS_NOISE: r_r        <= i_cfg_data[COV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_data.op == OP_RELOAD) ? S_HOLD : S_RUN;
                end
            end
            S_RUN:  if (w_core_stat.done) n_state = S_HOLD;
            S_HOLD: if (w_load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Filter state: loaded on reload, or written back when the core finishes a transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_est       <= '0;
            r_cov       <= Q_ONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && i_in_data.op == OP_RELOAD) begin
                r_est <= r_init_est;
                r_cov <= r_init_cov;
            end else if (r_state == S_RUN && w_core_stat.done) begin
                r_est <= w_core_est;
                r_cov <= w_core_cov;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data.estimate   <= r_est;
            r_out_data.covariance <= r_cov;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    skf_core #(
        .GAIN_BITS (GAIN_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_est    (r_est),
        .i_cov    (r_cov),
        .i_q      (r_q),
        .i_r      (r_r),
        .i_sample (i_in_data.sample),
        .o_stat   (w_core_stat),
        .o_est    (w_core_est),
        .o_cov    (w_core_cov)
    );

    // The core must be idle whenever the sequencer can accept a new transaction.
    `SKF_ASSERT_SAME(a_core_idle, r_state == S_IDLE, !w_core_stat.busy, "core busy while idle")
    // The core only completes while the sequencer waits for it.
    `SKF_ASSERT_SAME(a_done_in_run, w_core_stat.done, r_state == S_RUN, "core done outside run")
    // An accepted transaction closes the input for at least the next cycle.
    `SKF_ASSERT_NEXT(a_busy_after_accept, w_accept, !o_in_ready, "ready right after accept")
    // A new result only appears after the hold state.
    `SKF_ASSERT_SAME(a_out_from_hold, $rose(o_out_valid), $past(r_state == S_HOLD),
        "result raised outside hold")

endmodule
`default_nettype wire

// ----- sv/skf_core.sv -----
`default_nettype none
module skf_core #(
    parameter int GAIN_BITS = skf_pkg::SKF_GAIN_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic signed [skf_pkg::EST_W-1:0] i_est,
    input  wire logic [skf_pkg::COV_W-1:0]        i_cov,
    input  wire logic [skf_pkg::COV_W-1:0]        i_q,
    input  wire logic [skf_pkg::COV_W-1:0]        i_r,
    input  wire logic signed [skf_pkg::EST_W-1:0] i_sample,
    output skf_pkg::t_core_stat                   o_stat,
    output logic signed [skf_pkg::EST_W-1:0]      o_est,
    output logic [skf_pkg::COV_W-1:0]             o_cov
);
    import skf_pkg::*;

    localparam int G  = GAIN_BITS;
    localparam int CW = $clog2(GAIN_BITS);
    localparam logic [CW-1:0] LAST = CW'(GAIN_BITS - 1);
    localparam logic [G:0]    M_ONE = (G + 1)'(1) << G;

    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_PRED = 5'b00010,
        C_DIV  = 5'b00100,
        C_MUL  = 5'b01000,
        C_FIN  = 5'b10000
    } t_cstate;

    t_cstate                 r_state, n_state;
    logic [CW-1:0]           r_cnt;
    logic [COV_W-1:0]        r_p;
    logic [COV_W:0]          r_s;
    logic [COV_W:0]          r_rem;
    logic [G-1:0]            r_k;
    logic [G:0]              r_m;
    logic signed [EST_W:0]   r_d;
    logic signed [EST_W-1:0] r_est;
    logic signed [EST_W+2:0] r_acc_e;
    logic [COV_W:0]          r_acc_c;

    logic [COV_W:0]          w_pq;
    logic [COV_W:0]          w_s;
    logic [COV_W+1:0]        w_rem2;
    logic [COV_W+1:0]        w_rem_sub;
    logic                    w_ge;
    logic [G-1:0]            w_k_next;
    logic [G-1:0]            w_k_spec;
    logic [G-1:0]            w_k_sel;
    logic [G:0]              w_m_next;
    logic signed [EST_W+2:0] w_add_e;
    logic signed [EST_W+2:0] w_sum_e;
    logic [COV_W:0]          w_sum_c;

    // Predict: the covariance sum saturates at the largest 31-bit value.
    assign w_pq = {1'b0, i_cov} + {1'b0, i_q};
    assign w_s  = {1'b0, r_p} + {1'b0, i_r};

    // One restoring division step per cycle.
    assign w_rem2    = {r_rem, 1'b0};
    assign w_ge      = (w_rem2 >= {1'b0, r_s});
    assign w_rem_sub = w_rem2 - {1'b0, r_s};
    assign w_k_next  = {r_k[G-2:0], w_ge};

    // With no measurement noise the gain is one (clipped) or, for a zero sum, zero.
    assign w_k_spec = (r_p == '0) ? '0 : '1;
    assign w_k_sel  = (r_state == C_PRED) ? w_k_spec : w_k_next;
    assign w_m_next = M_ONE - {1'b0, w_k_sel};

    // Shift-add multiplications, one multiplier bit per cycle, least significant first.
    assign w_add_e = r_k[0] ? $signed({{2{r_d[EST_W]}}, r_d}) : '0;
    assign w_sum_e = r_acc_e + w_add_e;
    assign w_sum_c = r_acc_c + (r_m[0] ? {1'b0, r_p} : '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: if (i_start) n_state = C_PRED;
            C_PRED: n_state = (i_r == '0) ? C_MUL : C_DIV;
            C_DIV:  if (r_cnt == LAST) n_state = C_MUL;
            C_MUL:  if (r_cnt == LAST) n_state = C_FIN;
            C_FIN:  n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == C_DIV || r_state == C_MUL) && r_cnt != LAST) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            C_IDLE: begin
                r_p   <= w_pq[COV_W] ? '1 : w_pq[COV_W-1:0];
                r_d   <= $signed({i_sample[EST_W-1], i_sample}) - $signed({i_est[EST_W-1], i_est});
                r_est <= i_est;
            end
            C_PRED: begin
                r_s     <= w_s;
                r_rem   <= {1'b0, r_p};
                r_k     <= w_k_spec;
                r_m     <= w_m_next;
                r_acc_e <= '0;
                r_acc_c <= '0;
            end
            C_DIV: begin
                r_rem <= w_ge ? w_rem_sub[COV_W:0] : w_rem2[COV_W:0];
                r_k   <= w_k_next;
                if (r_cnt == LAST) begin
                    r_m <= w_m_next;
                end
            end
            C_MUL: begin
                r_acc_e <= w_sum_e >>> 1;
                r_acc_c <= w_sum_c >> 1;
                r_k     <= r_k >> 1;
                r_m     <= r_m >> 1;
            end
            C_FIN: begin
            end
            default: begin
            end
        endcase
    end

    // After the multiply phase the low bit of r_m is the top bit of (1 - K), set only for K = 0.
    assign o_est  = r_est + $signed(r_acc_e[EST_W-1:0]);
    assign o_cov  = r_m[0] ? r_p : r_acc_c[COV_W-1:0];
    assign o_stat = t_core_stat'{busy: (r_state != C_IDLE), done: (r_state == C_FIN)};

endmodule
`default_nettype wire

// ----- tb/scalar_kalman_filter_top_tb.sv -----
`timescale 1ns / 100ps

// Keeps a private copy of the filter state and registers, works out the result of every
// accepted input transaction and checks the results leaving the block in order.
class filter_scoreboard;
    localparam longint unsigned GAIN_ONE = 64'd1 << skf_pkg::SKF_GAIN_BITS;
    localparam longint unsigned COV_MAX  = 64'h7FFF_FFFF;

    logic signed [skf_pkg::EST_W-1:0] init_est;
    logic signed [skf_pkg::EST_W-1:0] est;
    logic [skf_pkg::COV_W-1:0]        init_cov;
    logic [skf_pkg::COV_W-1:0]        proc_var;
    logic [skf_pkg::COV_W-1:0]        meas_var;
    logic [skf_pkg::COV_W-1:0]        cov;
    skf_pkg::t_out_item               awaited[$];
    int mismatches;
    int checked;
    int reloads;
    int saturations;
    int zero_denoms;
    int clipped_gains;

    function new();
        init_est      = '0;
        est           = '0;
        init_cov      = skf_pkg::COV_W'(1 << skf_pkg::SKF_FRAC_BITS);
        proc_var      = skf_pkg::COV_W'(1 << skf_pkg::SKF_FRAC_BITS);
        meas_var      = skf_pkg::COV_W'(4 << skf_pkg::SKF_FRAC_BITS);
        cov           = skf_pkg::COV_W'(1 << skf_pkg::SKF_FRAC_BITS);
        mismatches    = 0;
        checked       = 0;
        reloads       = 0;
        saturations   = 0;
        zero_denoms   = 0;
        clipped_gains = 0;
    endfunction

    function void set_register(skf_pkg::t_cfg_idx idx, logic [skf_pkg::CFG_W-1:0] value);
        case (idx)
            skf_pkg::CFG_INIT_EST:   init_est = value;
            skf_pkg::CFG_INIT_COV:   init_cov = value[skf_pkg::COV_W-1:0];
            skf_pkg::CFG_PROC_NOISE: proc_var = value[skf_pkg::COV_W-1:0];
            skf_pkg::CFG_MEAS_NOISE: meas_var = value[skf_pkg::COV_W-1:0];
            default: ;
        endcase
    endfunction

    function void note_transaction(skf_pkg::t_in_item item);
        longint unsigned    p;
        longint unsigned    s;
        longint unsigned    k;
        longint unsigned    scaled_cov;
        longint signed      innov;
        longint signed      next_est;
        skf_pkg::t_out_item res;
        if (item.op == skf_pkg::OP_RELOAD) begin
            est = init_est;
            cov = init_cov;
            reloads++;
        end else begin
            p = 64'(cov) + 64'(proc_var);
            if (p > COV_MAX) begin
                p = COV_MAX;
                saturations++;
            end
            s = p + 64'(meas_var);
            if (s == 0) begin
                k = 0;
                zero_denoms++;
            end else begin
                k = (p << skf_pkg::SKF_GAIN_BITS) / s;
                if (k >= GAIN_ONE) begin
                    k = GAIN_ONE - 1;
                    clipped_gains++;
                end
            end
            innov      = longint'(item.sample) - longint'(est);
            // The arithmetic shift rounds the correction towards minus infinity.
            next_est   = longint'(est) + ((longint'(k) * innov) >>> skf_pkg::SKF_GAIN_BITS);
            scaled_cov = ((GAIN_ONE - k) * p) >> skf_pkg::SKF_GAIN_BITS;
            est        = next_est[skf_pkg::EST_W-1:0];
            cov        = scaled_cov[skf_pkg::COV_W-1:0];
        end
        res.estimate   = est;
        res.covariance = cov;
        awaited.push_back(res);
    endfunction

    function void check_result(skf_pkg::t_out_item got);
        skf_pkg::t_out_item want;
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result: estimate %0d, covariance %0d",
                         got.estimate, got.covariance);
        end else begin
            want = awaited.pop_front();
            checked++;
            if (got.estimate !== want.estimate || got.covariance !== want.covariance) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result %0d: estimate %0d (expected %0d), covariance %0d (expected %0d)",
                             checked, got.estimate, want.estimate,
                             got.covariance, want.covariance);
            end
        end
    endfunction
endclass

module scalar_kalman_filter_top_tb;
    import skf_pkg::*;

    // Eleven phases of random register settings plus three fixed ones, about 1750 items.
    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 125;
    // The slowest transaction is a filter, which runs both the divider and the multiplier; the
    // sender gap and the receiver stalls add to it, and this limit leaves a wide margin.
    localparam int QUIET_LIMIT     = 1000;
    localparam int TAIL_CYCLES     = 2 * (2 * SKF_GAIN_BITS + 3);

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out_data;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;

    filter_scoreboard book;
    int burst_left     = 0;
    int settings_count = 0;
    int quiet_cycles   = 0;

    wire in_fire  = i_in_valid && o_in_ready;
    wire out_fire = o_out_valid && i_out_ready;

    scalar_kalman_filter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // A sample value: mostly close to the current estimate at a random spread, so that the
    // filter settles and tracks, with the range extremes and wholly random words mixed in.
    function automatic logic signed [EST_W-1:0] pick_sample(logic signed [EST_W-1:0] centre);
        int            spread_bits;
        longint signed value;
        case ($urandom_range(0, 9))
            0:       value = -64'sd2147483648;
            1:       value = 64'sd2147483647;
            2, 3:    value = longint'($signed($urandom));
            default: begin
                spread_bits = $urandom_range(2, 26);
                value = longint'(centre) + longint'($urandom_range(0, 1 << spread_bits))
                        - (64'sd1 << (spread_bits - 1));
                if (value > 64'sd2147483647)
                    value = 64'sd2147483647;
                if (value < -64'sd2147483648)
                    value = -64'sd2147483648;
            end
        endcase
        return value[EST_W-1:0];
    endfunction

    // A variance register value. The top data bit lies outside the 31-bit registers, and
    // the all-ones word checks that the block drops it.
    function automatic logic [CFG_W-1:0] pick_variance();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3, 4:    return $urandom_range(0, 1 << 20);
            5:       return $urandom_range(1 << 14, 1 << 18);
            default: return $urandom;
        endcase
    endfunction

    // One register write; the enable stays high so that back-to-back writes need no toggle.
    task automatic write_register(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(posedge i_clk);
        book.set_register(idx, value);
    endtask

    // Writes all four registers and leaves the testbench at a falling edge.
    task automatic load_registers(input logic [CFG_W-1:0] est_v, input logic [CFG_W-1:0] cov_v,
                                  input logic [CFG_W-1:0] proc_v,
                                  input logic [CFG_W-1:0] meas_v);
        write_register(CFG_INIT_EST, est_v);
        write_register(CFG_INIT_COV, cov_v);
        write_register(CFG_PROC_NOISE, proc_v);
        write_register(CFG_MEAS_NOISE, meas_v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        settings_count++;
    endtask

    // Offers one input transaction and returns at the falling edge after its acceptance.
    // Transactions go out in bursts; between bursts valid drops for a random gap, and half
    // of the time there is no gap at all.
    task automatic send_item(input t_op op, input logic signed [EST_W-1:0] value);
        t_in_item item;
        int       gap;
        item.op     = op;
        item.sample = value;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 45);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_data  = item;
        i_in_valid = 1'b1;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        book.note_transaction(item);
        burst_left--;
        @(negedge i_clk);
    endtask

    // Closes a phase: the input goes quiet and every outstanding result is collected, so
    // that the block is idle before the registers are touched again.
    task automatic drain();
        i_in_valid = 1'b0;
        burst_left = 0;
        while (book.awaited.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        int  phase;
        int  n;
        t_op op;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        book        = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // From the reset state: a neutral sample, both sample extremes, then a reload that
        // must bring back the reset values of the initial registers.
        send_item(OP_FILTER, 32'sd0);
        send_item(OP_FILTER, 32'sh7FFF_FFFF);
        send_item(OP_FILTER, 32'sh8000_0000);
        send_item(OP_RELOAD, $urandom);
        drain();

        // Largest covariance and process noise with no measurement noise: the prediction
        // saturates and the gain of one is clipped, against the widest innovations.
        load_registers(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(OP_RELOAD, $urandom);
        send_item(OP_FILTER, 32'sh8000_0000);
        send_item(OP_FILTER, 32'sh7FFF_FFFF);
        send_item(OP_FILTER, 32'sd0);
        drain();

        // Zero covariance and noise: the denominator vanishes, so the estimate holds at its minimum.
        load_registers(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_RELOAD, $urandom);
        send_item(OP_FILTER, 32'sh7FFF_FFFF);
        send_item(OP_FILTER, 32'sd0);
        drain();

        // Equal and largest variances give a gain close to one half; the measurement noise
        // word carries a set top bit that must be dropped.
        load_registers(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_RELOAD, $urandom);
        send_item(OP_FILTER, 32'sh7FFF_FFFF);
        send_item(OP_FILTER, -32'sd1);
        send_item(OP_FILTER, 32'sd1);
        drain();

        // Zero prediction over a tiny measurement noise: the division runs and yields zero.
        load_registers(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        send_item(OP_RELOAD, $urandom);
        send_item(OP_FILTER, 32'sd12345);
        drain();

        // Random phases: the reset settings first, then the zero-noise extreme, then random
        // settings, and finally the saturating extreme. About one transaction in ten is a
        // reload, the rest are measurements around the tracked estimate.
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == 0)
                load_registers(32'd0, 32'd1 << SKF_FRAC_BITS, 32'd1 << SKF_FRAC_BITS,
                               32'd4 << SKF_FRAC_BITS);
            else if (phase == 1)
                load_registers(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
            else if (phase == PHASES - 1)
                load_registers(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0);
            else
                load_registers(pick_sample(32'sd0), pick_variance(), pick_variance(),
                               pick_variance());
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                op = OP_FILTER;
                if ($urandom_range(0, 9) == 0)
                    op = OP_RELOAD;
                send_item(op, pick_sample(book.est));
            end
            drain();
        end

        // A quiet stretch after the last result catches any spurious output transaction.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d results, %0d of them reloads, over %0d register settings.",
                 book.checked, book.reloads, settings_count);
        $display("Saturated predictions %0d, zero denominators %0d, clipped gains %0d, errors %0d.",
                 book.saturations, book.zero_denoms, book.clipped_gains, book.mismatches);
        if (book.mismatches == 0 && book.awaited.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // The receiver alternates between stalls, short ready spells, single-cycle jitter and
    // long stretches with no stall at all.
    initial begin : receiver
        int hold;
        int level;
        hold        = 0;
        level       = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold == 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        level = 0;
                        hold  = $urandom_range(1, 30);
                    end
                    1: begin
                        level = 1;
                        hold  = $urandom_range(1, 8);
                    end
                    2: begin
                        level = 1;
                        hold  = $urandom_range(50, 300);
                    end
                    default: begin
                        level = $urandom_range(0, 1);
                        hold  = 1;
                    end
                endcase
            end
            i_out_ready = (level != 0);
            hold--;
        end
    end

    // Every output transaction is checked against the oldest expected result.
    always @(posedge i_clk) begin
        if (i_rst_n && out_fire)
            book.check_result(o_out_data);
    end

    // The run ends if neither channel moves a transaction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, book.awaited.size());
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end
endmodule

// ----- scalar_kalman_filter_top.f -----
+incdir+sv
sv/skf_pkg.sv
sv/skf_core.sv
sv/scalar_kalman_filter_top.sv
tb/scalar_kalman_filter_top_tb.sv
